// ===== hdl/att_pkg.sv =====
// Shared types and constants for the alarm timer table.
// Used by att_slot_tbl and alarm_timer_table; depends on nothing else.
package att_pkg;

    // Table geometry
    localparam int NUM_ALARMS = 8;
    localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

    // Field widths
    localparam int CNT_W = 24;
    localparam int EV_W  = 8;
    localparam int AUX_W = 32;
    localparam int PER_W = 16;

    // Stream widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    localparam logic [PER_W-1:0] TICK_PERIOD_RST = PER_W'(10);

    // Input selector codes (tuser)
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    // Result kind codes (tuser)
    localparam logic KIND_FIRE = 1'b0;
    localparam logic KIND_OVFL = 1'b1;

    // Slot write operations
    typedef enum logic [1:0] {
        WR_SET,
        WR_COUNT,
        WR_FREE
    } t_wr_op;

    // One slot as seen on the read port
    typedef struct packed {
        logic             valid;
        logic             periodic;
        logic [CNT_W-1:0] reload;
        logic [CNT_W-1:0] count;
        logic [EV_W-1:0]  event_id;
        logic [AUX_W-1:0] aux;
    } t_slot;

    // Write command from the sequencer to the slot table
    typedef struct packed {
        logic             en;
        t_wr_op           op;
        logic [IDX_W-1:0] idx;
        logic             periodic;
        logic [CNT_W-1:0] reload;
        logic [CNT_W-1:0] count;
        logic [EV_W-1:0]  event_id;
        logic [AUX_W-1:0] aux;
    } t_slot_wr;

endpackage

// ===== hdl/att_slot_tbl.sv =====
// Alarm slot storage: valid bits with reset, per-slot payload without.
// Depends on att_pkg for the slot and write command types.
module att_slot_tbl
    import att_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_slot            o_rd,
    input  t_slot_wr         i_wr
);

    logic             r_valid    [NUM_ALARMS];
    logic             r_periodic [NUM_ALARMS];
    logic [CNT_W-1:0] r_reload   [NUM_ALARMS];
    logic [CNT_W-1:0] r_count    [NUM_ALARMS];
    logic [EV_W-1:0]  r_event    [NUM_ALARMS];
    logic [AUX_W-1:0] r_aux      [NUM_ALARMS];

    // Valid bits: set on a new alarm, clear on cancel or one-shot fire
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ALARMS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_wr.en) begin
            unique case (i_wr.op)
                WR_SET:   r_valid[i_wr.idx] <= 1'b1;
                WR_FREE:  r_valid[i_wr.idx] <= 1'b0;
                WR_COUNT: r_valid[i_wr.idx] <= r_valid[i_wr.idx];
                default:  r_valid[i_wr.idx] <= r_valid[i_wr.idx];
            endcase
        end
    end

    // Payload: full load on set, count update on tick
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            if (i_wr.op == WR_SET) begin
                r_periodic[i_wr.idx] <= i_wr.periodic;
                r_reload[i_wr.idx]   <= i_wr.reload;
                r_count[i_wr.idx]    <= i_wr.count;
                r_event[i_wr.idx]    <= i_wr.event_id;
                r_aux[i_wr.idx]      <= i_wr.aux;
            end else if (i_wr.op == WR_COUNT) begin
                r_count[i_wr.idx]    <= i_wr.count;
            end
        end
    end

    // Read the slot under the scan index
    always_comb begin
        o_rd.valid    = r_valid[i_rd_idx];
        o_rd.periodic = r_periodic[i_rd_idx];
        o_rd.reload   = r_reload[i_rd_idx];
        o_rd.count    = r_count[i_rd_idx];
        o_rd.event_id = r_event[i_rd_idx];
        o_rd.aux      = r_aux[i_rd_idx];
    end

endmodule

// ===== hdl/alarm_timer_table.sv =====
// Alarm timer table top level: request stream, sequencer, result stream.
// Depends on att_pkg and att_slot_tbl.
//
// The block holds NUM_ALARMS alarm slots and visits them one per cycle, unless
// a result stall holds the scan, with a single 25-bit subtract/compare unit and
// one key comparator. A set stops at the first free or matching slot; a cancel
// visits every slot; a tick always visits every slot. The request side is ready
// only between items. Results leave through an output register, so the final
// result of an item may still wait on the master side while the next request
// is taken; a tick stalls on a firing slot while one result is parked and the
// output register is still full, and an overflow waits at the last slot for
// the output register. Each fired alarm gives one result, the last one of a
// tick and every overflow result carry tlast. The tick period register may be
// written at any time the block is idle and is always ready.
module alarm_timer_table
    import att_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write: tick_period_ms
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [PER_W-1:0]     i_cfg_data,
    // Request stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata: periodic[0], delay_ms[24:1], event_id[32:25], aux_word[64:33], zero
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: func[0]
    input  logic [0:0]           i_s_axis_tuser,
    // Result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata: fired_event[7:0], fired_aux[39:8]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: result_kind[0]
    output logic [0:0]           o_m_axis_tuser,
    output logic                 o_m_axis_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [PER_W-1:0] r_period, n_period;

    // Request fields, held for the whole scan
    logic             r_func;
    logic             r_per;
    logic [CNT_W-1:0] r_delay;
    logic [EV_W-1:0]  r_ev;
    logic [AUX_W-1:0] r_aux;

    // Result waiting to learn whether it is the last of the tick
    logic             r_pend_vld, n_pend_vld;
    logic [EV_W-1:0]  r_pend_ev, n_pend_ev;
    logic [AUX_W-1:0] r_pend_aux, n_pend_aux;

    // Output register
    logic             r_m_valid, n_m_valid;
    logic             r_m_kind, n_m_kind;
    logic             r_m_last, n_m_last;
    logic [EV_W-1:0]  r_m_ev, n_m_ev;
    logic [AUX_W-1:0] r_m_aux, n_m_aux;

    t_slot            w_rd;
    t_slot_wr         w_wr;
    logic [CNT_W:0]   w_diff;
    logic             w_fire;
    logic             w_match;
    logic             w_last_idx;
    logic             w_out_free;
    logic             w_in_xfer;

    att_slot_tbl u_slots (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .o_rd     (w_rd),
        .i_wr     (w_wr)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_aux, r_m_ev};
    assign o_m_axis_tuser  = r_m_kind;
    assign o_m_axis_tlast  = r_m_last;

    // Shared unit: count minus period, borrow means the slot fires
    assign w_diff     = {1'b0, w_rd.count} - {{(CNT_W + 1 - PER_W){1'b0}}, r_period};
    assign w_fire     = w_diff[CNT_W];
    assign w_match    = w_rd.valid && (w_rd.event_id == r_ev) && (w_rd.aux == r_aux);
    assign w_last_idx = (r_idx == IDX_W'(NUM_ALARMS - 1));
    assign w_out_free = !r_m_valid || i_m_axis_tready;

    // Sequencer: walk slots, issue slot writes, move results out
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_period   = r_period;
        n_pend_vld = r_pend_vld;
        n_pend_ev  = r_pend_ev;
        n_pend_aux = r_pend_aux;
        n_m_valid  = r_m_valid;
        n_m_kind   = r_m_kind;
        n_m_last   = r_m_last;
        n_m_ev     = r_m_ev;
        n_m_aux    = r_m_aux;

        w_wr.en       = 1'b0;
        w_wr.op       = WR_COUNT;
        w_wr.idx      = r_idx;
        w_wr.periodic = r_per;
        w_wr.reload   = r_delay;
        w_wr.count    = r_delay;
        w_wr.event_id = r_ev;
        w_wr.aux      = r_aux;

        // Drop the output once the master takes it
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        if (i_cfg_valid && o_cfg_ready) begin
            n_period = i_cfg_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (r_func == FUNC_SET && r_delay == '0) begin
                    // Cancel: free every matching slot
                    if (w_match) begin
                        w_wr.en = 1'b1;
                        w_wr.op = WR_FREE;
                    end
                    if (w_last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else if (r_func == FUNC_SET) begin
                    // Set: take the first free or matching slot
                    if (!w_rd.valid || w_match) begin
                        w_wr.en = 1'b1;
                        w_wr.op = WR_SET;
                        n_state = ST_IDLE;
                    end else if (w_last_idx) begin
                        // Table full: report overflow once the output is free
                        if (w_out_free) begin
                            n_m_valid = 1'b1;
                            n_m_kind  = KIND_OVFL;
                            n_m_last  = 1'b1;
                            n_m_ev    = r_ev;
                            n_m_aux   = r_aux;
                            n_state   = ST_IDLE;
                        end
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    // Tick: decrement or fire
                    if (!w_rd.valid) begin
                        if (w_last_idx) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_idx = r_idx + IDX_W'(1);
                        end
                    end else if (!w_fire) begin
                        w_wr.en    = 1'b1;
                        w_wr.op    = WR_COUNT;
                        w_wr.count = w_diff[CNT_W-1:0];
                        if (w_last_idx) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_idx = r_idx + IDX_W'(1);
                        end
                    end else if (!r_pend_vld || w_out_free) begin
                        // Push the previous result out, park this one
                        if (r_pend_vld) begin
                            n_m_valid = 1'b1;
                            n_m_kind  = KIND_FIRE;
                            n_m_last  = 1'b0;
                            n_m_ev    = r_pend_ev;
                            n_m_aux   = r_pend_aux;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_ev  = w_rd.event_id;
                        n_pend_aux = w_rd.aux;
                        w_wr.en    = 1'b1;
                        w_wr.op    = w_rd.periodic ? WR_COUNT : WR_FREE;
                        w_wr.count = w_rd.reload;
                        if (w_last_idx) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_idx = r_idx + IDX_W'(1);
                        end
                    end
                end
            end

            ST_FLUSH: begin
                // Send the parked result as the last of the tick
                if (!r_pend_vld) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_kind   = KIND_FIRE;
                    n_m_last   = 1'b1;
                    n_m_ev     = r_pend_ev;
                    n_m_aux    = r_pend_aux;
                    n_pend_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_period   <= TICK_PERIOD_RST;
            r_pend_vld <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_period   <= n_period;
            r_pend_vld <= n_pend_vld;
            r_pend_ev  <= n_pend_ev;
            r_pend_aux <= n_pend_aux;
            r_m_valid  <= n_m_valid;
            r_m_kind   <= n_m_kind;
            r_m_last   <= n_m_last;
            r_m_ev     <= n_m_ev;
            r_m_aux    <= n_m_aux;
        end
    end

    // Capture the request on transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_func  <= i_s_axis_tuser[0];
            r_per   <= i_s_axis_tdata[0];
            r_delay <= i_s_axis_tdata[CNT_W:1];
            r_ev    <= i_s_axis_tdata[CNT_W+EV_W:CNT_W+1];
            r_aux   <= i_s_axis_tdata[CNT_W+EV_W+AUX_W:CNT_W+EV_W+1];
        end
    end

    // Nothing stays parked once the block is idle
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_vld)
        else $error("parked result left behind in idle");

    // A request starts its scan at slot zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_SCAN) && (r_idx == '0))
        else $error("scan did not start at slot zero");

    // Overflow is always the only and last result of its request
    a_ovfl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_kind == KIND_OVFL) |-> r_m_last)
        else $error("overflow result without tlast");

    // A non-final fire result always has a successor parked
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_last) |-> r_pend_vld)
        else $error("non-final result with no follower");

endmodule
